[hdl/tlpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared widths, codes and constants for the two-level page table updater.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int FRAME_W   = 20;
    localparam int ATTR_W    = 12;
    localparam int ENTRY_W   = 32;
    localparam int IDX_W     = 10;
    localparam int ENTRIES   = 1024;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NEW_TABLE = 2'd1;
    localparam logic [1:0] STAT_NO_DIR    = 2'd2;
    localparam logic [1:0] STAT_FAULT     = 2'd3;

    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    localparam logic [FRAME_W-1:0] POOL_BASE_RESET = 20'd256;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [ATTR_W-1:0]  attr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

[hdl/tlpt_frame_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_frame_chk
// Maps a physical frame to its table store offset and flags frames outside
// the store window (window wraps at 2^20).
// ----------------------------------------------------------------------------
module tlpt_frame_chk
    import tlpt_pkg::*;
#(
    parameter int STORE_FRAMES = 64,
    parameter int OFF_W        = 6
) (
    input  frame_t             frame,
    input  frame_t             base,
    output logic [OFF_W-1:0]   off,
    output logic               in_store
);

    frame_t delta;

    assign delta    = frame - base;
    assign in_store = (delta < FRAME_W'(STORE_FRAMES));
    assign off      = delta[OFF_W-1:0];

endmodule

[hdl/two_level_page_table_updater_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_updater_top
// Map / unmap engine for 32-bit two-level page tables held in an on-chip
// table store, with bump allocation of new page tables from the store.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   tvalid/tready      tuser: kind; tdata: dir frame, vpage,
//                                    phys frame, attributes
//  m_        out  tvalid/tready      tdata: result_frame, status
//  cfg_      in   cfg_we             cfg_wdata: pool_base_frame
//
//  One request at a time: accept, dir read, check, entry write or
//  read+clear, result; a new table adds its clear sweep through the
//  single store port.
//  After reset a clearing pass writes all STORE_FRAMES*1024 entries, one
//  per cycle; s_tready stays low during it.
//  Result sits in an output register; a new beat is taken while it waits.
// ----------------------------------------------------------------------------
module two_level_page_table_updater_top
    import tlpt_pkg::*;
#(
    parameter int STORE_FRAMES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  frame_t                cfg_wdata,     // pool_base_frame

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,       // directory_frame, virtual_page,
                                                 // physical_frame, attributes
    input  logic                  s_tuser,       // kind

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata        // result_frame, status, pad
);

    localparam int OFF_W  = $clog2(STORE_FRAMES);
    localparam int ADDR_W = OFF_W + IDX_W;
    localparam int DEPTH  = STORE_FRAMES * ENTRIES;
    localparam int NFI_W  = $clog2(STORE_FRAMES + 1);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIR_RD  = 4'd2;
    localparam logic [3:0] S_DIR_CHK = 4'd3;
    localparam logic [3:0] S_TBL_CLR = 4'd4;
    localparam logic [3:0] S_PDE_WR  = 4'd5;
    localparam logic [3:0] S_TBL_WR  = 4'd6;
    localparam logic [3:0] S_TBL_RD  = 4'd7;
    localparam logic [3:0] S_TBL_ZAP = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [NFI_W-1:0]   nfi_reg, nfi_next;
    frame_t             base_reg, base_next;
    logic               m_valid_reg, m_valid_next;
    logic               created_reg, created_next;

    logic               kind_reg, kind_next;
    frame_t             vpage_reg, vpage_next;
    frame_t             pframe_reg, pframe_next;
    attr_t              attrs_reg, attrs_next;
    logic [OFF_W-1:0]   doff_reg, doff_next;
    logic [OFF_W-1:0]   toff_reg, toff_next;
    frame_t             res_frame_reg, res_frame_next;
    logic [1:0]         res_stat_reg, res_stat_next;
    frame_t             m_frame_reg, m_frame_next;
    logic [1:0]         m_stat_reg, m_stat_next;

    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    entry_t             mem_wdata;

    logic [OFF_W-1:0]   in_doff, pde_toff;
    logic               in_dir_ok, pde_tbl_ok;
    logic [IDX_W-1:0]   dir_idx, tab_idx;
    frame_t             new_frame;
    attr_t              attrs_p;
    logic               accept, out_load;

    assign dir_idx   = vpage_reg[FRAME_W-1:IDX_W];
    assign tab_idx   = vpage_reg[IDX_W-1:0];
    assign new_frame = base_reg + {{(FRAME_W-NFI_W){1'b0}}, nfi_reg};
    assign attrs_p   = {attrs_reg[ATTR_W-1:1], 1'b1};

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-FRAME_W-2){1'b0}}, m_stat_reg, m_frame_reg};

    tlpt_frame_chk #(
        .STORE_FRAMES (STORE_FRAMES),
        .OFF_W        (OFF_W)
    ) u_dir_chk (
        .frame    (s_tdata[FRAME_W-1:0]),
        .base     (base_reg),
        .off      (in_doff),
        .in_store (in_dir_ok)
    );

    tlpt_frame_chk #(
        .STORE_FRAMES (STORE_FRAMES),
        .OFF_W        (OFF_W)
    ) u_tbl_chk (
        .frame    (rdata_reg[ENTRY_W-1:ATTR_W]),
        .base     (base_reg),
        .off      (pde_toff),
        .in_store (pde_tbl_ok)
    );

    // store port
    always_comb begin
        mem_addr  = {toff_reg, tab_idx};
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            S_INIT, S_TBL_CLR: begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
            end
            S_DIR_RD: begin
                mem_addr = {doff_reg, dir_idx};
            end
            S_PDE_WR: begin
                mem_addr  = {doff_reg, dir_idx};
                mem_we    = 1'b1;
                mem_wdata = {new_frame, attrs_p};
            end
            S_TBL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {pframe_reg, attrs_p};
            end
            S_TBL_ZAP: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        nfi_next       = nfi_reg;
        base_next      = cfg_we ? cfg_wdata : base_reg;
        created_next   = created_reg;
        kind_next      = kind_reg;
        vpage_next     = vpage_reg;
        pframe_next    = pframe_reg;
        attrs_next     = attrs_reg;
        doff_next      = doff_reg;
        toff_next      = toff_reg;
        res_frame_next = res_frame_reg;
        res_stat_next  = res_stat_reg;
        m_frame_next   = m_frame_reg;
        m_stat_next    = m_stat_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;

        unique case (state_reg)
            S_INIT: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    kind_next      = s_tuser;
                    vpage_next     = s_tdata[2*FRAME_W-1:FRAME_W];
                    pframe_next    = s_tdata[3*FRAME_W-1:2*FRAME_W];
                    attrs_next     = s_tdata[3*FRAME_W+ATTR_W-1:3*FRAME_W];
                    doff_next      = in_doff;
                    created_next   = 1'b0;
                    res_frame_next = '0;
                    res_stat_next  = STAT_FAULT;
                    state_next     = in_dir_ok ? S_DIR_RD : S_FIN;
                end
            end
            S_DIR_RD: begin
                state_next = S_DIR_CHK;
            end
            S_DIR_CHK: begin
                toff_next = pde_toff;
                priority if (!rdata_reg[0] && kind_reg == KIND_UNMAP) begin
                    res_stat_next = STAT_NO_DIR;
                    state_next    = S_FIN;
                end else if (!rdata_reg[0]) begin
                    if (nfi_reg >= NFI_W'(STORE_FRAMES)) begin
                        state_next = S_FIN;
                    end else begin
                        clr_next     = {nfi_reg[OFF_W-1:0], {IDX_W{1'b0}}};
                        toff_next    = nfi_reg[OFF_W-1:0];
                        created_next = 1'b1;
                        state_next   = S_TBL_CLR;
                    end
                end else if (!pde_tbl_ok) begin
                    state_next = S_FIN;
                end else if (kind_reg == KIND_UNMAP) begin
                    state_next = S_TBL_RD;
                end else begin
                    state_next = S_TBL_WR;
                end
            end
            S_TBL_CLR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg[IDX_W-1:0] == {IDX_W{1'b1}}) begin
                    state_next = S_PDE_WR;
                end
            end
            S_PDE_WR: begin
                nfi_next   = nfi_reg + 1'b1;
                state_next = S_TBL_WR;
            end
            S_TBL_WR: begin
                res_stat_next = created_reg ? STAT_NEW_TABLE : STAT_OK;
                state_next    = S_FIN;
            end
            S_TBL_RD: begin
                state_next = S_TBL_ZAP;
            end
            S_TBL_ZAP: begin
                res_frame_next = rdata_reg[ENTRY_W-1:ATTR_W];
                res_stat_next  = STAT_OK;
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    m_frame_next = res_frame_reg;
                    m_stat_next  = res_stat_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            clr_reg     <= '0;
            nfi_reg     <= '0;
            base_reg    <= POOL_BASE_RESET;
            m_valid_reg <= 1'b0;
            created_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            nfi_reg     <= nfi_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
            created_reg <= created_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        vpage_reg     <= vpage_next;
        pframe_reg    <= pframe_next;
        attrs_reg     <= attrs_next;
        doff_reg      <= doff_next;
        toff_reg      <= toff_next;
        res_frame_reg <= res_frame_next;
        res_stat_reg  <= res_stat_next;
        m_frame_reg   <= m_frame_next;
        m_stat_reg    <= m_stat_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        nfi_reg <= NFI_W'(STORE_FRAMES))
        else $error("pool index past store size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PDE_WR) |=> (nfi_reg == $past(nfi_reg) + 1'b1))
        else $error("new table without pool index advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_FIN) |-> !mem_we)
        else $error("store write outside a request step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result beat not from completion step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TBL_WR && !created_reg) |-> (res_stat_reg == STAT_FAULT))
        else $error("stale status before table write");

endmodule
